[hw/rtl/hrp_pkg.sv]
// Shared types, constants and character helpers for the HTTP response header parser.
package hrp_pkg;

    localparam int DEF_LINE_LIMIT = 255;
    localparam int NAME_LEN       = 15;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [31:0] HDR_END = 32'h0D0A0D0A;

    localparam logic [9:0] STATUS_MAX = 10'd999;
    localparam logic [9:0] ST_400 = 10'd400;
    localparam logic [9:0] ST_401 = 10'd401;
    localparam logic [9:0] ST_403 = 10'd403;
    localparam logic [9:0] ST_404 = 10'd404;
    localparam logic [9:0] ST_500 = 10'd500;
    localparam logic [9:0] ST_503 = 10'd503;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_400   = 3'd1;
    localparam logic [2:0] ERR_401   = 3'd2;
    localparam logic [2:0] ERR_403   = 3'd3;
    localparam logic [2:0] ERR_404   = 3'd4;
    localparam logic [2:0] ERR_500   = 3'd5;
    localparam logic [2:0] ERR_503   = 3'd6;
    localparam logic [2:0] ERR_OTHER = 3'd7;

    localparam logic [2:0] PREFIX_LEN = 3'd5;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_FIND_SPACE,
        PH_SKIP_WS,
        PH_DIGITS,
        PH_HEADERS,
        PH_ERROR,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        NUM_SKIP,
        NUM_DIGITS,
        NUM_DONE
    } num_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_response;
    } hrp_in_t;

    typedef struct packed {
        logic              body_valid;
        logic [7:0]        body_byte;
        logic              headers_done;
        logic [9:0]        status_num;
        logic signed [31:0] hdr_length;
        logic [2:0]        status_error;
    } hrp_out_t;

    typedef struct packed {
        logic       body_valid;
        logic [9:0] status_num;
        logic [2:0] status_error;
    } hrp_status_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
    endfunction

    // "HTTP/"
    function automatic logic [7:0] http_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h48;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h50;
            3'd4:    ch = 8'h2F;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "content-length:" in lower case
    function automatic logic [7:0] cl_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h63;
            4'd1:    ch = 8'h6F;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6E;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h2D;
            4'd8:    ch = 8'h6C;
            4'd9:    ch = 8'h65;
            4'd10:   ch = 8'h6E;
            4'd11:   ch = 8'h67;
            4'd12:   ch = 8'h74;
            4'd13:   ch = 8'h68;
            4'd14:   ch = 8'h3A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] err_of(input logic [9:0] s);
        logic [2:0] e;
        priority if (s == ST_400) e = ERR_400;
        else if (s == ST_401)     e = ERR_401;
        else if (s == ST_403)     e = ERR_403;
        else if (s == ST_404)     e = ERR_404;
        else if (s == ST_500)     e = ERR_500;
        else if (s == ST_503)     e = ERR_503;
        else                      e = ERR_OTHER;
        return e;
    endfunction

endpackage

[hw/rtl/hrp_status.sv]
// Status line parser: HTTP/ prefix, status number, error code and phase tracking.
module hrp_status
    import hrp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic        clear,
    input  logic [7:0]  data_byte,
    input  logic        done_hit,
    output logic        run_line,
    output hrp_status_t status
);

    phase_t     phase_reg, phase_next;
    logic [2:0] step_reg, step_next;
    logic [9:0] value_reg, value_next;
    logic [2:0] error_reg, error_next;

    phase_t     ph, feed_phase;
    logic [2:0] step;
    logic [9:0] val;
    logic [2:0] err;
    logic       eol, digit, do_acc, do_end;
    logic [13:0] acc;

    always_comb begin
        ph   = clear ? PH_PREFIX : phase_reg;
        step = clear ? 3'd0 : step_reg;
        val  = clear ? 10'd0 : value_reg;
        err  = clear ? ERR_NONE : error_reg;

        eol   = (data_byte == CHAR_CR) || (data_byte == CHAR_LF) || (data_byte == CHAR_NUL);
        digit = is_digit(data_byte);
        acc   = ({4'd0, val} << 3) + ({4'd0, val} << 1) + {10'd0, data_byte[3:0]};

        feed_phase = ph;
        step_next  = step;
        value_next = val;
        error_next = err;
        do_acc     = 1'b0;
        do_end     = 1'b0;

        unique case (ph)
            PH_PREFIX: begin
                if ((step < PREFIX_LEN) && (data_byte == http_char(step))) begin
                    if (step == PREFIX_LEN - 3'd1) begin
                        step_next  = 3'd0;
                        feed_phase = PH_FIND_SPACE;
                    end else begin
                        step_next = step + 3'd1;
                    end
                end else begin
                    feed_phase = PH_HEADERS;
                end
            end
            PH_FIND_SPACE: begin
                if (data_byte == CHAR_SPACE) feed_phase = PH_SKIP_WS;
                else if (eol)                feed_phase = PH_HEADERS;
            end
            PH_SKIP_WS: begin
                if (is_blank(data_byte)) begin
                    feed_phase = PH_SKIP_WS;
                end else if ((data_byte == CHAR_PLUS) || (data_byte == CHAR_MINUS)) begin
                    step_next  = {2'b00, data_byte == CHAR_MINUS};
                    feed_phase = PH_DIGITS;
                end else if (!digit) begin
                    feed_phase = PH_HEADERS;
                end else begin
                    // first digit counts right away, sign is positive
                    step_next  = 3'd0;
                    feed_phase = PH_DIGITS;
                    do_acc     = 1'b1;
                end
            end
            PH_DIGITS: begin
                if (digit) do_acc = !step[0];
                else       do_end = 1'b1;
            end
            default: begin
            end
        endcase

        if (do_acc) begin
            value_next = (acc > {4'd0, STATUS_MAX}) ? STATUS_MAX : acc[9:0];
        end
        if (do_end) begin
            if (val >= ST_400) begin
                error_next = err_of(val);
                feed_phase = PH_ERROR;
            end else begin
                feed_phase = PH_HEADERS;
            end
        end

        run_line = (ph != PH_BODY) && (feed_phase != PH_ERROR);

        status.body_valid   = (ph == PH_BODY);
        status.status_num   = value_next;
        status.status_error = error_next;
    end

    // header terminator seen by the line unit moves on to body
    assign phase_next = (run_line && done_hit) ? PH_BODY : feed_phase;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PREFIX;
            step_reg  <= 3'd0;
            value_reg <= 10'd0;
            error_reg <= ERR_NONE;
        end else if (advance) begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            value_reg <= value_next;
            error_reg <= error_next;
        end
    end

endmodule

[hw/rtl/hrp_line.sv]
// Header line scanner: Content-Length match and value, CRLFCRLF detection.
module hrp_line
    import hrp_pkg::*;
#(
    parameter int LINE_LIMIT = DEF_LINE_LIMIT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               clear,
    input  logic               run,
    input  logic [7:0]         data_byte,
    output logic               done_hit,
    output logic signed [31:0] hdr_length
);

    localparam int POS_W = $clog2(LINE_LIMIT + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_LIMIT);
    localparam logic [POS_W-1:0] POS_NAME  = POS_W'(NAME_LEN);
    localparam logic [35:0] CAP_POS = 36'h07FFFFFFF;
    localparam logic [35:0] CAP_NEG = 36'h080000000;

    logic [31:0]      last4_reg, last4_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             match_reg, match_next;
    num_phase_t       nph_reg, nph_next;
    logic             neg_reg, neg_next;
    logic [31:0]      num_reg, num_next;
    logic [31:0]      len_reg, len_next;

    logic [31:0]      last4;
    logic [POS_W-1:0] pos;
    logic             match;
    num_phase_t       nph;
    logic             neg;
    logic [31:0]      num;
    logic [31:0]      len;
    logic             take_digit;
    logic [35:0]      acc, cap;

    always_comb begin
        last4 = clear ? 32'd0 : last4_reg;
        pos   = clear ? '0 : pos_reg;
        match = clear ? 1'b1 : match_reg;
        nph   = clear ? NUM_SKIP : nph_reg;
        neg   = clear ? 1'b0 : neg_reg;
        num   = clear ? 32'd0 : num_reg;
        len   = clear ? 32'hFFFF_FFFF : len_reg;

        acc = ({4'd0, num} << 3) + ({4'd0, num} << 1) + {32'd0, data_byte[3:0]};
        cap = neg ? CAP_NEG : CAP_POS;

        last4_next = last4;
        pos_next   = pos;
        match_next = match;
        nph_next   = nph;
        neg_next   = neg;
        num_next   = num;
        len_next   = len;
        take_digit = 1'b0;
        done_hit   = 1'b0;

        if (run) begin
            last4_next = {last4[23:0], data_byte};
            done_hit   = (last4_next == HDR_END);
            if ((data_byte == CHAR_CR) || (data_byte == CHAR_LF)) begin
                if (pos != '0) begin
                    if (match && (pos >= POS_NAME)) begin
                        len_next = neg ? (~num + 32'd1) : num;
                    end
                    pos_next   = '0;
                    match_next = 1'b1;
                    nph_next   = NUM_SKIP;
                    neg_next   = 1'b0;
                    num_next   = 32'd0;
                end
            end else if (pos < POS_LIMIT) begin
                if (pos < POS_NAME) begin
                    if (to_lower(data_byte) != cl_char(pos[3:0])) match_next = 1'b0;
                end else if (match) begin
                    unique case (nph)
                        NUM_SKIP: begin
                            if (is_blank(data_byte)) begin
                                nph_next = NUM_SKIP;
                            end else if ((data_byte == CHAR_PLUS) ||
                                         (data_byte == CHAR_MINUS)) begin
                                neg_next = (data_byte == CHAR_MINUS);
                                nph_next = NUM_DIGITS;
                            end else begin
                                take_digit = 1'b1;
                            end
                        end
                        NUM_DIGITS: take_digit = 1'b1;
                        default: begin
                        end
                    endcase
                    if (take_digit) begin
                        if (!is_digit(data_byte)) begin
                            nph_next = NUM_DONE;
                        end else begin
                            nph_next = NUM_DIGITS;
                            num_next = (acc > cap) ? cap[31:0] : acc[31:0];
                        end
                    end
                end
                pos_next = pos + POS_W'(1);
            end
        end

        hdr_length = len_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last4_reg <= 32'd0;
            pos_reg   <= '0;
            match_reg <= 1'b1;
            nph_reg   <= NUM_SKIP;
            neg_reg   <= 1'b0;
            num_reg   <= 32'd0;
            len_reg   <= 32'hFFFF_FFFF;
        end else if (advance) begin
            last4_reg <= last4_next;
            pos_reg   <= pos_next;
            match_reg <= match_next;
            nph_reg   <= nph_next;
            neg_reg   <= neg_next;
            num_reg   <= num_next;
            len_reg   <= len_next;
        end
    end

endmodule

[hw/rtl/http_response_header_parser.sv]
// Top level of the HTTP/1.0 response header parser: input register, parse units, result register.
//
//   channel   dir   handshake          word
//   s_        in    s_valid/s_ready    s_word (hrp_in_t: data_byte, new_response)
//   m_        out   m_valid/m_ready    m_word (hrp_out_t: body/status/length results)
//
// One result word per input word. A word sits in the input register while the
// status and line units update their state and the result register loads, so
// results come from the result register, and a word can be taken every cycle while m_ready is high.
// aresetn (synchronous, active low) clears all parse state; new_response does
// the same for the word that carries it. A low m_ready holds the result
// register; the input register then takes one more word and s_ready drops
// until the result drains.
module http_response_header_parser
    import hrp_pkg::*;
#(
    parameter int LINE_LIMIT = DEF_LINE_LIMIT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  hrp_in_t  s_word,
    output logic     m_valid,
    input  logic     m_ready,
    output hrp_out_t m_word
);

    hrp_in_t     in_reg;
    logic        in_valid_reg;
    hrp_out_t    out_reg, out_next;
    logic        out_valid_reg;

    logic        advance;
    logic        run_line;
    logic        done_hit;
    logic signed [31:0] hdr_length;
    hrp_status_t status;

    // process the held word whenever the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    hrp_status u_status (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .clear     (in_reg.new_response),
        .data_byte (in_reg.data_byte),
        .done_hit  (done_hit),
        .run_line  (run_line),
        .status    (status)
    );

    hrp_line #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_line (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .clear      (in_reg.new_response),
        .run        (run_line),
        .data_byte  (in_reg.data_byte),
        .done_hit   (done_hit),
        .hdr_length (hdr_length)
    );

    always_comb begin
        out_next.body_valid   = status.body_valid;
        out_next.body_byte    = status.body_valid ? in_reg.data_byte : 8'd0;
        out_next.headers_done = done_hit;
        out_next.status_num   = status.status_num;
        out_next.hdr_length   = hdr_length;
        out_next.status_error = status.status_error;
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_word;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_reg;

endmodule

[tb/hrp_tracker_pkg.sv]
`timescale 1ns / 100ps
// Header-parse tracker: predicts every result word of the parser and checks the DUT output.
package hrp_tracker_pkg;
    import hrp_pkg::*;

    localparam int    LINE_MAX = DEF_LINE_LIMIT;
    localparam string HTTP_TAG = "HTTP/";
    localparam string LEN_TAG  = "content-length:";

    class header_tracker;
        phase_t      phase;
        logic [2:0]  step;      // tag index, later bit 0 = negative status
        logic [9:0]  status;
        logic [2:0]  err;
        logic [31:0] tail;      // last four bytes
        int          col;
        bit          name_ok;
        num_phase_t  nphase;
        bit          neg;
        logic [31:0] mag;
        logic [31:0] length;
        hrp_out_t    parsed_q[$];
        int          fails;

        function new();
            fails = 0;
            clear_all();
        endfunction

        function void clear_line();
            col     = 0;
            name_ok = 1'b1;
            nphase  = NUM_SKIP;
            neg     = 1'b0;
            mag     = '0;
        endfunction

        function void clear_all();
            phase  = PH_PREFIX;
            step   = '0;
            status = '0;
            err    = ERR_NONE;
            tail   = '0;
            clear_line();
            length = '1;
        endfunction

        function bit blank_char(logic [7:0] c);
            return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF;
        endfunction

        function bit digit_char(logic [7:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        // Advance the parse by one accepted word and queue the word it must produce.
        function void take_byte(hrp_in_t w);
            logic [7:0]  c;
            logic [7:0]  lc;
            logic [63:0] acc;
            logic [63:0] cap;
            int unsigned v;
            bit          run_digits;
            bit          eol;
            hrp_out_t    r;

            c = w.data_byte;
            if (w.new_response)
                clear_all();
            eol  = (c == CHAR_CR || c == CHAR_LF || c == CHAR_NUL);
            r    = '0;

            if (phase == PH_BODY) begin
                r.body_valid = 1'b1;
                r.body_byte  = c;
            end else if (phase != PH_ERROR) begin
                // status line
                run_digits = 1'b0;
                case (phase)
                    PH_PREFIX: begin
                        if (step < PREFIX_LEN && c == HTTP_TAG[step]) begin
                            step++;
                            if (step == PREFIX_LEN) begin
                                step  = '0;
                                phase = PH_FIND_SPACE;
                            end
                        end else begin
                            phase = PH_HEADERS;
                        end
                    end
                    PH_FIND_SPACE: begin
                        if (c == CHAR_SPACE)
                            phase = PH_SKIP_WS;
                        else if (eol)
                            phase = PH_HEADERS;
                    end
                    PH_SKIP_WS: begin
                        if (!blank_char(c)) begin
                            if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                                step  = {2'b00, c == CHAR_MINUS};
                                phase = PH_DIGITS;
                            end else if (!digit_char(c)) begin
                                phase = PH_HEADERS;
                            end else begin
                                step       = '0;
                                phase      = PH_DIGITS;
                                run_digits = 1'b1;
                            end
                        end
                    end
                    PH_DIGITS: run_digits = 1'b1;
                    default: ;
                endcase

                if (run_digits) begin
                    if (digit_char(c)) begin
                        if (!step[0]) begin
                            v      = 32'(status) * 32'd10 + 32'(c - 8'h30);
                            status = (v > 32'(STATUS_MAX)) ? STATUS_MAX : v[9:0];
                        end
                    end else if (status >= ST_400) begin
                        case (status)
                            ST_400:  err = ERR_400;
                            ST_401:  err = ERR_401;
                            ST_403:  err = ERR_403;
                            ST_404:  err = ERR_404;
                            ST_500:  err = ERR_500;
                            ST_503:  err = ERR_503;
                            default: err = ERR_OTHER;
                        endcase
                        phase = PH_ERROR;
                    end else begin
                        phase = PH_HEADERS;
                    end
                end

                if (phase != PH_ERROR) begin
                    // header line scan
                    if (c == CHAR_CR || c == CHAR_LF) begin
                        if (col > 0) begin
                            if (name_ok && col >= NAME_LEN)
                                length = neg ? -mag : mag;
                            clear_line();
                        end
                    end else if (col < LINE_MAX) begin
                        if (col < NAME_LEN) begin
                            lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
                            if (lc != LEN_TAG[col])
                                name_ok = 1'b0;
                        end else if (name_ok && nphase != NUM_DONE) begin
                            if (nphase == NUM_SKIP && blank_char(c)) begin
                                // leading blanks
                            end else if (nphase == NUM_SKIP &&
                                         (c == CHAR_PLUS || c == CHAR_MINUS)) begin
                                neg    = (c == CHAR_MINUS);
                                nphase = NUM_DIGITS;
                            end else if (!digit_char(c)) begin
                                nphase = NUM_DONE;
                            end else begin
                                nphase = NUM_DIGITS;
                                cap    = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
                                acc    = {32'b0, mag} * 10 + (c - 8'h30);
                                if (acc > cap)
                                    acc = cap;
                                mag = acc[31:0];
                            end
                        end
                        col++;
                    end

                    tail = {tail[23:0], c};
                    if (tail == HDR_END) begin
                        r.headers_done = 1'b1;
                        phase          = PH_BODY;
                    end
                end
            end

            r.status_num   = status;
            r.hdr_length   = length;
            r.status_error = err;
            parsed_q.push_back(r);
        endfunction

        function void note_diff(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
                fails++;
            end
        endfunction

        function void match_result(hrp_out_t got);
            hrp_out_t want;
            if (parsed_q.size() == 0) begin
                $display("%0t: result word with none pending, actual 0x%0h", $time, got);
                fails++;
                return;
            end
            want = parsed_q.pop_front();
            note_diff("body_valid", 32'(want.body_valid), 32'(got.body_valid));
            note_diff("body_byte", 32'(want.body_byte), 32'(got.body_byte));
            note_diff("headers_done", 32'(want.headers_done), 32'(got.headers_done));
            note_diff("status_num", 32'(want.status_num), 32'(got.status_num));
            note_diff("hdr_length", want.hdr_length, got.hdr_length);
            note_diff("status_error", 32'(want.status_error), 32'(got.status_error));
        endfunction
    endclass

endpackage

[tb/tb_http_response_header_parser.sv]
`timescale 1ns / 100ps
// Top of the parser testbench: reset, directed bytes, random responses, result checks.
module tb_http_response_header_parser;
    import hrp_pkg::*;
    import hrp_tracker_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int ITEM_GOAL   = 1150;  // words before the stimulus stops
    localparam int CALM_AFTER  = 1000;  // no idling on either side past this point
    localparam int TAIL_WAIT   = 20;    // plenty of margin over the parser latency
    localparam int CYCLE_CAP   = 400000;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    hrp_in_t  s_word  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    hrp_out_t m_word;

    header_tracker board;
    logic [7:0]    resp_q[$];        // bytes of the response being built
    int            sent_words = 0;   // words accepted so far
    bit            idle_on    = 1'b0;
    int            stall_left = 0;
    int unsigned   cycles     = 0;

    http_response_header_parser #(
        .LINE_LIMIT(LINE_MAX)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Run limit; a healthy run finishes far below it.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random stall bursts while idling is on.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 16);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every accepted result word is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.match_result(m_word);
    end

    // ---- byte builders -------------------------------------------------

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            resp_q.push_back(s[i]);
    endfunction

    function automatic void put_crlf();
        resp_q.push_back(CHAR_CR);
        resp_q.push_back(CHAR_LF);
    endfunction

    function automatic void put_digits(input int n);
        repeat (n) resp_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
    endfunction

    // Mix of space, tab, VT and FF.
    function automatic void put_blanks(input int n);
        logic [7:0] blank_set [4];
        blank_set = '{CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF};
        repeat (n) resp_q.push_back(blank_set[$urandom_range(0, 3)]);
    endfunction

    // First upto chars of the length header name in random case; the char at
    // index flip (if any) is replaced by '#', which never matches.
    function automatic void put_name(input int upto, input int flip);
        logic [7:0] ch;
        for (int i = 0; i < upto; i++) begin
            ch = (i == flip) ? 8'h23 : LEN_TAG[i];
            if (ch >= 8'h61 && ch <= 8'h7A && $urandom_range(0, 1) == 1)
                ch = ch - 8'd32;
            resp_q.push_back(ch);
        end
    endfunction

    function automatic void put_sign();
        case ($urandom_range(0, 5))
            0:       resp_q.push_back(CHAR_MINUS);
            1:       resp_q.push_back(CHAR_PLUS);
            default: ;
        endcase
    endfunction

    // ---- driving --------------------------------------------------------

    // Sends the built response word by word; fresh marks its first word as a
    // new response. Valid stays up back to back unless a gap burst is drawn.
    task automatic send_response(input bit fresh);
        hrp_in_t w;
        for (int i = 0; i < resp_q.size(); i++) begin
            w.data_byte    = resp_q[i];
            w.new_response = fresh && (i == 0);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_word  <= w;
            do @(posedge aclk); while (!s_ready);
            board.take_byte(w);
            sent_words++;
        end
        resp_q.delete();
    endtask

    // Holds the input side off until every predicted word has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.parsed_q.size() != 0) @(posedge aclk);
    endtask

    // ---- stimulus -------------------------------------------------------

    initial begin
        logic [9:0] known [8];
        int         pick;
        int         kind;
        bit         fresh;
        bit         force_long;
        bit         paused;

        known = '{ST_400, ST_401, ST_403, ST_404, ST_500, ST_503, 10'd200, 10'd301};
        board = new();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: 404 then ignored extremes, bare terminator then body
        // extremes, and a status line that ends before any space.
        put_text("HTTP/ 404 ");
        resp_q.push_back(8'hFF);
        resp_q.push_back(CHAR_NUL);
        send_response(1'b1);
        put_crlf();
        put_crlf();
        resp_q.push_back(CHAR_NUL);
        resp_q.push_back(8'hFF);
        send_response(1'b1);
        put_text("HTTP/");
        resp_q.push_back(CHAR_CR);
        send_response(1'b1);
        wait_drained();

        // Random responses: mostly well formed with random content, some noise.
        force_long = 1'b1;
        paused     = 1'b0;
        while (sent_words < ITEM_GOAL) begin
            idle_on = (sent_words < CALM_AFTER) && ($urandom_range(0, 3) != 0);
            fresh   = ($urandom_range(0, 11) != 0);
            pick    = $urandom_range(0, 9);

            if (pick == 0) begin
                // raw noise, no structure at all
                repeat ($urandom_range(4, 30)) resp_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                // status line
                if (pick == 1) begin
                    // one char of the protocol tag is wrong (bit 5 flipped)
                    kind = $urandom_range(0, 4);
                    for (int i = 0; i < 5; i++)
                        resp_q.push_back(i == kind ? HTTP_TAG[i] ^ 8'h20 : HTTP_TAG[i]);
                    put_text("1.0 200 OK");
                    put_crlf();
                end else if (pick == 2) begin
                    // line ends (CR, LF or NUL) before the status space
                    put_text("HTTP/1.1");
                    case ($urandom_range(0, 2))
                        0:       resp_q.push_back(CHAR_CR);
                        1:       resp_q.push_back(CHAR_LF);
                        default: resp_q.push_back(CHAR_NUL);
                    endcase
                    put_text(" 200");
                    put_crlf();
                end else begin
                    put_text("HTTP/1.0 ");
                    put_blanks($urandom_range(0, 2));
                    if (pick == 3) begin
                        // no digits: blank skip runs into text or the line end
                        if ($urandom_range(0, 1) == 1)
                            put_text("OK");
                    end else begin
                        put_sign();
                        case ($urandom_range(0, 3))
                            0:       put_text($sformatf("%0d", known[$urandom_range(0, 7)]));
                            1:       put_text($sformatf("%0d", $urandom_range(0, 999)));
                            2:       put_digits($urandom_range(1, 6));
                            default: put_text("200");
                        endcase
                        if ($urandom_range(0, 1) == 1)
                            put_text(" OK");
                    end
                    put_crlf();
                end

                // header lines
                repeat (force_long ? 2 : $urandom_range(0, 3)) begin
                    kind = force_long ? 39 : $urandom_range(0, 39);
                    force_long = 1'b0;
                    if (kind < 18) begin
                        // length header: blanks, sign, digits, then a terminator
                        put_name(NAME_LEN, -1);
                        put_blanks($urandom_range(0, 2));
                        put_sign();
                        case ($urandom_range(0, 5))
                            0:       put_text("2147483647");
                            1:       put_text("2147483648");
                            2:       put_digits($urandom_range(11, 14));
                            3:       ;
                            default: put_digits($urandom_range(1, 9));
                        endcase
                        case ($urandom_range(0, 5))
                            0: begin
                                resp_q.push_back(CHAR_NUL);
                                put_digits(2);
                            end
                            1:       put_text(" 7");
                            2:       put_text("x9");
                            default: ;
                        endcase
                    end else if (kind < 23) begin
                        put_name(NAME_LEN, $urandom_range(0, NAME_LEN - 1));
                        put_text(" 55");
                    end else if (kind < 27) begin
                        put_name($urandom_range(1, NAME_LEN - 1), -1);
                    end else if (kind < 34) begin
                        put_text($sformatf("X-Id: %0d", $urandom_range(0, 99999)));
                    end else if (kind < 39) begin
                        repeat ($urandom_range(1, 20))
                            resp_q.push_back(8'($urandom_range(0, 255)));
                    end else if ($urandom_range(0, 1) == 1) begin
                        // value digits straddle the line cut
                        put_name(NAME_LEN, -1);
                        put_blanks($urandom_range(220, 245));
                        put_digits(20);
                    end else begin
                        repeat ($urandom_range(LINE_MAX - 5, LINE_MAX + 20))
                            resp_q.push_back(8'($urandom_range(33, 126)));
                    end
                    case ($urandom_range(0, 9))
                        0:       resp_q.push_back(CHAR_LF);
                        1:       resp_q.push_back(CHAR_CR);
                        default: put_crlf();
                    endcase
                end

                // blank line closes the header block, body follows
                put_crlf();
                repeat ($urandom_range(0, 16)) resp_q.push_back(8'($urandom_range(0, 255)));
            end

            send_response(fresh);

            if (!paused && sent_words >= ITEM_GOAL / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        idle_on = 1'b0;
        wait_drained();
        repeat (TAIL_WAIT) @(posedge aclk);
        if (board.fails == 0 && board.parsed_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
